// ===== sv/nfbp_pkg.sv =====
// Shared types, codes and small arithmetic helpers of the numeric field BCD packer.
// No dependencies; imported by nfbp_skid, nfbp_core and the top level.
package nfbp_pkg;

    typedef enum logic [1:0] {
        LK_FIXED  = 2'd0,
        LK_ASCII2 = 2'd1,
        LK_ASCII3 = 2'd2,
        LK_BCD2   = 2'd3
    } length_kind_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DIGIT = 1'b1
    } opcode_t;

    // register index, taken from paddr[2]
    localparam logic REG_LENGTH_KIND = 1'b0;
    localparam logic REG_FIELD_LEN   = 1'b1;

    localparam int unsigned COUNT_W = 14;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned FLEN_W  = 7;

    localparam logic [7:0]         ASCII_ZERO = 8'h30;
    localparam logic [COUNT_W-1:0] LIM_ASCII2 = COUNT_W'(100 - 1);
    localparam logic [COUNT_W-1:0] LIM_ASCII3 = COUNT_W'(1000 - 1);
    localparam logic [COUNT_W-1:0] LIM_BCD2   = COUNT_W'(10000 - 1);

    typedef struct packed {
        opcode_t              opcode;
        logic [COUNT_W-1:0]   digit_count;
        logic [CHAR_W-1:0]    digit_char;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       too_long;
        logic       last;
    } result_t;

    typedef struct packed {
        length_kind_t        length_kind;
        logic [FLEN_W-1:0]   field_len;
    } cfg_t;

    // ASCII hex digit to nibble; letters of either case, others wrap
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end else begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    // x / 10 for x below 100, reciprocal multiply
    function automatic logic [3:0] div10(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

    // x / 100 for any 14-bit x, low seven bits of the quotient
    function automatic logic [6:0] div100(input logic [COUNT_W-1:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd5243;
        return p[25:19];
    endfunction

endpackage

// ===== sv/nfbp_skid.sv =====
// Input skid buffer of the packer: two item registers, registered ready.
// Depends on nfbp_pkg for the item type.
module nfbp_skid
    import nfbp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_take,
    output item_t out_item
);

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    item_t main_item_reg, main_item_next;
    item_t skid_item_reg, skid_item_next;
    logic  in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_item  = main_item_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_item_next  = main_item_reg;
        skid_item_next  = skid_item_reg;
        if (!main_valid_reg || out_take) begin
            main_valid_next = skid_valid_reg || in_fire;
            main_item_next  = skid_valid_reg ? skid_item_reg : in_item;
            skid_valid_next = 1'b0;
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_item_next  = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

// ===== sv/nfbp_core.sv =====
// Field state, prefix/padding byte sequencer and result register of the packer.
// Depends on nfbp_pkg for types, codes and the decimal helpers.
module nfbp_core
    import nfbp_pkg::*;
#(
    parameter int unsigned MAX_FIXED_DIGITS = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_take,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int unsigned EFF_W = $clog2(MAX_FIXED_DIGITS + 1);
    localparam int unsigned PAD_W = $clog2((MAX_FIXED_DIGITS + 1) / 2 + 1);
    localparam logic [7:0]  MAX_W8 = 8'(MAX_FIXED_DIGITS);

    // field state
    logic [COUNT_W-1:0] digits_left_reg, digits_left_next;
    logic               odd_pending_reg, odd_pending_next;
    logic [3:0]         high_nibble_reg, high_nibble_next;
    logic               have_high_reg, have_high_next;
    logic               dropping_reg, dropping_next;

    // byte run after a start word
    logic               burst_active_reg, burst_active_next;
    logic               burst_err_reg, burst_err_next;
    length_kind_t       burst_kind_reg, burst_kind_next;
    logic [1:0]         burst_idx_reg, burst_idx_next;
    logic [PAD_W-1:0]   pad_left_reg, pad_left_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [6:0]         q100_reg, q100_next;
    logic [6:0]         r100_reg;

    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic               out_free;
    logic [7:0]         fl8;
    logic [EFF_W-1:0]   eff;
    logic [COUNT_W-1:0] lim;
    logic               too_long;
    logic [COUNT_W:0]   half_eff, half_cnt;
    logic [PAD_W-1:0]   pad;
    logic [6:0]         dec_src;
    logic [3:0]         dec_tens, dec_ones;
    logic [3:0]         digit;
    logic [COUNT_W-1:0] dl_dec;

    assign out_free  = !res_valid_reg || res_ready;
    assign item_take = item_valid && !burst_active_reg && out_free;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // limit check and padding of a start word
    assign fl8 = {1'b0, cfg.field_len};
    assign eff = EFF_W'((fl8 > MAX_W8) ? MAX_W8 : fl8);

    always_comb begin
        unique case (cfg.length_kind)
            LK_FIXED:  lim = COUNT_W'(eff);
            LK_ASCII2: lim = LIM_ASCII2;
            LK_ASCII3: lim = LIM_ASCII3;
            LK_BCD2:   lim = LIM_BCD2;
            default:   lim = LIM_BCD2;
        endcase
    end

    assign too_long = item.digit_count > lim;
    assign half_eff = ((COUNT_W + 1)'(eff) + 1'b1) >> 1;
    assign half_cnt = ((COUNT_W + 1)'(item.digit_count) + 1'b1) >> 1;
    assign pad      = PAD_W'(half_eff - half_cnt);

    // two decimal digits of the byte being sent
    always_comb begin
        if (burst_kind_reg == LK_ASCII2) begin
            dec_src = cnt_reg[6:0];
        end else if (burst_kind_reg == LK_BCD2 && burst_idx_reg == 2'd0) begin
            dec_src = q100_reg;
        end else begin
            dec_src = r100_reg;
        end
    end

    assign dec_tens = div10(dec_src);
    assign dec_ones = 4'(dec_src - 7'(dec_tens) * 7'd10);

    assign digit  = hex_nibble(item.digit_char);
    assign dl_dec = digits_left_reg - 1'b1;

    always_comb begin
        digits_left_next  = digits_left_reg;
        odd_pending_next  = odd_pending_reg;
        high_nibble_next  = high_nibble_reg;
        have_high_next    = have_high_reg;
        dropping_next     = dropping_reg;
        burst_active_next = burst_active_reg;
        burst_err_next    = burst_err_reg;
        burst_kind_next   = burst_kind_reg;
        burst_idx_next    = burst_idx_reg;
        pad_left_next     = pad_left_reg;
        cnt_next          = cnt_reg;
        q100_next         = q100_reg;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && !res_ready;

        if (burst_active_reg && out_free) begin
            res_valid_next      = 1'b1;
            res_next.byte_valid = 1'b1;
            res_next.too_long   = 1'b0;
            res_next.out_byte   = 8'h00;
            res_next.last       = 1'b0;
            if (burst_err_reg) begin
                res_next.byte_valid = 1'b0;
                res_next.too_long   = 1'b1;
                res_next.last       = 1'b1;
            end else begin
                unique case (burst_kind_reg)
                    LK_FIXED: begin
                        res_next.last = (pad_left_reg == PAD_W'(1));
                    end
                    LK_ASCII2: begin
                        res_next.out_byte = ASCII_ZERO +
                            8'((burst_idx_reg == 2'd0) ? dec_tens : dec_ones);
                        res_next.last = (burst_idx_reg == 2'd1);
                    end
                    LK_ASCII3: begin
                        unique case (burst_idx_reg)
                            2'd0:    res_next.out_byte = ASCII_ZERO + 8'(q100_reg[3:0]);
                            2'd1:    res_next.out_byte = ASCII_ZERO + 8'(dec_tens);
                            default: res_next.out_byte = ASCII_ZERO + 8'(dec_ones);
                        endcase
                        res_next.last = (burst_idx_reg == 2'd2);
                    end
                    LK_BCD2: begin
                        res_next.out_byte = {dec_tens, dec_ones};
                        res_next.last     = (burst_idx_reg == 2'd1);
                    end
                    default: begin
                        res_next.last = 1'b1;
                    end
                endcase
            end
            if (res_next.last) begin
                burst_active_next = 1'b0;
            end
            burst_idx_next = burst_idx_reg + 1'b1;
            pad_left_next  = pad_left_reg - 1'b1;
        end else if (item_take) begin
            if (item.opcode == OP_START) begin
                have_high_next    = 1'b0;
                high_nibble_next  = 4'h0;
                digits_left_next  = item.digit_count;
                dropping_next     = too_long;
                odd_pending_next  = !too_long && item.digit_count[0];
                burst_err_next    = too_long;
                burst_kind_next   = cfg.length_kind;
                burst_idx_next    = 2'd0;
                pad_left_next     = pad;
                cnt_next          = item.digit_count;
                q100_next         = div100(item.digit_count);
                burst_active_next = too_long || (cfg.length_kind != LK_FIXED) ||
                                    (pad != '0);
            end else if (digits_left_reg != '0) begin
                digits_left_next = dl_dec;
                if (dropping_reg) begin
                    if (dl_dec == '0) begin
                        dropping_next = 1'b0;
                    end
                end else if (odd_pending_reg) begin
                    odd_pending_next = 1'b0;
                    res_valid_next   = 1'b1;
                    res_next         = '{out_byte: {4'h0, digit}, byte_valid: 1'b1,
                                         too_long: 1'b0, last: 1'b1};
                end else if (!have_high_reg) begin
                    have_high_next   = 1'b1;
                    high_nibble_next = digit;
                end else begin
                    have_high_next   = 1'b0;
                    high_nibble_next = 4'h0;
                    res_valid_next   = 1'b1;
                    res_next         = '{out_byte: {high_nibble_reg, digit}, byte_valid: 1'b1,
                                         too_long: 1'b0, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_left_reg  <= '0;
            odd_pending_reg  <= 1'b0;
            high_nibble_reg  <= 4'h0;
            have_high_reg    <= 1'b0;
            dropping_reg     <= 1'b0;
            burst_active_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
        end else begin
            digits_left_reg  <= digits_left_next;
            odd_pending_reg  <= odd_pending_next;
            high_nibble_reg  <= high_nibble_next;
            have_high_reg    <= have_high_next;
            dropping_reg     <= dropping_next;
            burst_active_reg <= burst_active_next;
            res_valid_reg    <= res_valid_next;
        end
        burst_err_reg  <= burst_err_next;
        burst_kind_reg <= burst_kind_next;
        burst_idx_reg  <= burst_idx_next;
        pad_left_reg   <= pad_left_next;
        cnt_reg        <= cnt_next;
        q100_reg       <= q100_next;
        // remainder is registered from cnt_reg and q100_reg, one register behind them; first used on the second byte
        r100_reg       <= 7'(cnt_reg - 14'(q100_reg) * 14'd100);
        res_reg        <= res_next;
    end

endmodule

// ===== sv/numeric_field_bcd_packer.sv =====
// Top level of the numeric field BCD packer: config registers and channel wiring.
// Depends on nfbp_pkg, nfbp_skid and nfbp_core.
//
//  channel  | direction | handshake         | word contents
//  ---------+-----------+-------------------+---------------------------------------
//  s_       | in        | s_tvalid/s_tready | start (count) or digit (hex char)
//  m_       | out       | m_tvalid/m_tready | prefix, padding, digit byte or error
//  APB      | in        | psel/penable      | length_kind @0x0, field_len @0x4
//
// Digit words stream at one per cycle while m_tready is high and no byte run is active.
// A start word is decoded when taken; a sequencer then sends its prefix or padding
// bytes (up to three prefix bytes or (MAX_FIXED_DIGITS+1)/2 padding bytes),
// and digit words wait behind that byte run.
// An over-long count yields a single error word in place of the byte run.
// Reset is synchronous on aresetn low and clears all field state.
// s_tready comes from the skid register and m_tvalid from the result register,
// so neither side sees a combinational path from the other.
module numeric_field_bcd_packer
    import nfbp_pkg::*;
#(
    parameter int unsigned MAX_FIXED_DIGITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [13:0] digit_count, [21:14] digit_char, rest zero
    input  logic        s_tuser,   // [0] opcode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] too_long
    output logic        m_tlast,   // last word caused by the input word
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    length_kind_t      length_kind_reg;
    logic [FLEN_W-1:0] field_len_reg;
    cfg_t              cfg;
    logic              cfg_wr;

    item_t   s_item, core_item;
    logic    core_valid, core_take;
    result_t res;

    // register index is paddr[2]; low address bits are not decoded
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_kind_reg <= LK_FIXED;
            field_len_reg   <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LENGTH_KIND) begin
                length_kind_reg <= length_kind_t'(pwdata[1:0]);
            end else begin
                field_len_reg <= pwdata[FLEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FIELD_LEN) begin
            prdata = {25'd0, field_len_reg};
        end else begin
            prdata = {30'd0, length_kind_reg};
        end
    end

    assign cfg.length_kind = length_kind_reg;
    assign cfg.field_len   = field_len_reg;

    assign s_item.opcode      = opcode_t'(s_tuser);
    assign s_item.digit_count = s_tdata[COUNT_W-1:0];
    assign s_item.digit_char  = s_tdata[COUNT_W+CHAR_W-1:COUNT_W];

    nfbp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_take  (core_take),
        .out_item  (core_item)
    );

    nfbp_core #(
        .MAX_FIXED_DIGITS (MAX_FIXED_DIGITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (core_valid),
        .item       (core_item),
        .item_take  (core_take),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = res.out_byte;
    assign m_tuser = {res.too_long, res.byte_valid};
    assign m_tlast = res.last;

endmodule

// ===== sv/nfbp_checker.sv =====
// Port-level checker of the numeric field BCD packer and its bind.
// Depends on numeric_field_bcd_packer's port list only.
module nfbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        pready
);

    // a held result word keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // every word is either a byte or an error, never both nor neither
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] ^ m_tuser[1]))
        else $error("result word is neither a byte nor an error");

    // error word stands alone, carries no byte
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00))
        else $error("error word not alone or carries data");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind numeric_field_bcd_packer nfbp_checker u_nfbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
